/* rtl/core/tga_rle_pixel_decoder_unit_assert.svh */
// ---------------------------------------------------------------------------
// TGA RLE pixel decoder: assertion macros
// Concurrent assertion helpers used by the port checker. Both sample on the
// rising edge of clk and are switched off while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef TGA_RLE_PIXEL_DECODER_UNIT_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define TGARLE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define TGARLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/tgarle_pkg.sv */
// ---------------------------------------------------------------------------
// TGA RLE pixel decoder: shared package
// Register indexes, configuration and result types, and the pixel size rule.
// ---------------------------------------------------------------------------
`default_nettype none

package tgarle_pkg;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_RLE_MODE    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_BYTES = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_TOTAL = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [2:0]  PIXEL_BYTES_RST = 3'd4;
	localparam logic [31:0] PIXEL_TOTAL_RST = 32'd1;

	// Live configuration seen by the decoder.
	typedef struct packed {
		logic        rle_mode;
		logic [2:0]  pixel_bytes;
		logic [31:0] pixel_total;
	} cfg_t;

	// One decoded run.
	typedef struct packed {
		logic [31:0] pixel_value;
		logic [7:0]  run_count;
		logic        image_done;
	} result_t;

	// Bytes per pixel as used: zero counts as one, anything above four as four.
	function automatic logic [2:0] eff_bytes(input logic [2:0] pb);
		logic [2:0] nb;
		if (pb == 3'd0) begin
			nb = 3'd1;
		end else if (pb > 3'd4) begin
			nb = 3'd4;
		end else begin
			nb = pb;
		end
		return nb;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/tgarle_cfg.sv */
// ---------------------------------------------------------------------------
// TGA RLE pixel decoder: configuration registers
// Holds rle_mode, pixel_bytes and pixel_total; writes to unknown indexes are
// dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module tgarle_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [tgarle_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [31:0]                         cfg_data,
	output tgarle_pkg::cfg_t                         cfg
);

	tgarle_pkg::cfg_t cfg_q;

	// The register file takes a word in every cycle.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rle_mode    <= 1'b0;
			cfg_q.pixel_bytes <= tgarle_pkg::PIXEL_BYTES_RST;
			cfg_q.pixel_total <= tgarle_pkg::PIXEL_TOTAL_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				tgarle_pkg::CFG_RLE_MODE:    cfg_q.rle_mode    <= cfg_data[0];
				tgarle_pkg::CFG_PIXEL_BYTES: cfg_q.pixel_bytes <= cfg_data[2:0];
				tgarle_pkg::CFG_PIXEL_TOTAL: cfg_q.pixel_total <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/tgarle_in_reg.sv */
// ---------------------------------------------------------------------------
// TGA RLE pixel decoder: input register
// Registers one body byte from the slave stream and holds it until the
// decoder takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module tgarle_in_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,
	input  wire logic       take,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	logic vld_s1;

	// A word may enter when the stage is empty or is being emptied.
	assign s_tready = !vld_s1 || take;
	assign valid_s1 = vld_s1;

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/tgarle_core.sv */
// ---------------------------------------------------------------------------
// TGA RLE pixel decoder: decode core
// Packet, pixel and image counters with the result register. Each registered
// byte is either a packet header, a middle byte of a pixel, or the last byte
// of a pixel, which yields one run.
// ---------------------------------------------------------------------------
`default_nettype none

module tgarle_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tgarle_pkg::cfg_t   cfg,
	input  wire logic               valid_s1,
	input  wire logic [7:0]         byte_s1,
	output logic                    take,
	output logic                    valid_s2,
	output tgarle_pkg::result_t     result_s2,
	input  wire logic               out_ready
);

	logic [7:0]  packet_left_q;
	logic        repeat_q;
	logic [1:0]  byte_pos_q;
	logic [23:0] assembly_q;
	logic [31:0] pixels_left_q;
	logic        vld_s2;

	logic [2:0]  nbytes;
	logic [31:0] pl_eff;
	logic        is_header;
	logic        is_accum;
	logic        is_emit;
	logic [2:0]  bp_inc;
	logic [4:0]  shift;
	logic [31:0] pix_raw;
	logic [31:0] pix_mask;
	logic [31:0] pix_m;
	logic [31:0] pix;
	logic [23:0] assembly_acc;
	logic [7:0]  count;
	logic [31:0] pl_next;
	logic        done;
	logic [7:0]  hdr_count;
	logic        fire;

	// The result register frees up when empty or when its word is taken.
	assign take     = !vld_s2 || out_ready;
	assign fire     = valid_s1 && take;
	assign valid_s2 = vld_s2;

	// Decode of the registered byte.
	always_comb begin
		nbytes = tgarle_pkg::eff_bytes(cfg.pixel_bytes);

		// A fresh image loads its pixel count; an empty image counts as one pixel.
		if (pixels_left_q == 32'd0) begin
			pl_eff = (cfg.pixel_total == 32'd0) ? 32'd1 : cfg.pixel_total;
		end else begin
			pl_eff = pixels_left_q;
		end

		is_header = cfg.rle_mode && (packet_left_q == 8'd0);
		bp_inc    = {1'b0, byte_pos_q} + 3'd1;
		is_accum  = !is_header && (bp_inc < nbytes);
		is_emit   = !is_header && !is_accum;
		shift     = {byte_pos_q, 3'b000};

		assembly_acc = assembly_q | ({16'h0000, byte_s1} << shift);

		// Final pixel: bytes received so far plus this one, upper bytes cleared.
		pix_raw = {8'h00, assembly_q} | ({24'h000000, byte_s1} << shift);
		case (byte_pos_q)
			2'd0:    pix_mask = 32'h0000_00FF;
			2'd1:    pix_mask = 32'h0000_FFFF;
			2'd2:    pix_mask = 32'h00FF_FFFF;
			default: pix_mask = 32'hFFFF_FFFF;
		endcase
		pix_m = pix_raw & pix_mask;

		// Colour pixels arrive as BGR and leave as RGB.
		if (nbytes >= 3'd3) begin
			pix = {pix_m[31:24], pix_m[7:0], pix_m[15:8], pix_m[23:16]};
		end else begin
			pix = pix_m;
		end

		// A repeat run is clipped to the pixels left in the image.
		if (cfg.rle_mode && repeat_q) begin
			if ({24'h000000, packet_left_q} > pl_eff) begin
				count = pl_eff[7:0];
			end else begin
				count = packet_left_q;
			end
		end else begin
			count = 8'd1;
		end
		if (count == 8'd0) begin
			count = 8'd1;
		end

		pl_next   = pl_eff - {24'h000000, count};
		done      = (pl_next == 32'd0);
		hdr_count = {1'b0, byte_s1[6:0]} + 8'd1;
	end

	// Packet, pixel and image state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_left_q <= 8'd0;
			repeat_q      <= 1'b0;
			byte_pos_q    <= 2'd0;
			assembly_q    <= 24'd0;
			pixels_left_q <= 32'd0;
		end else if (fire) begin
			if (is_header) begin
				packet_left_q <= hdr_count;
				repeat_q      <= byte_s1[7];
				byte_pos_q    <= 2'd0;
				assembly_q    <= 24'd0;
				pixels_left_q <= pl_eff;
			end else if (is_accum) begin
				byte_pos_q    <= bp_inc[1:0];
				assembly_q    <= assembly_acc;
				pixels_left_q <= pl_eff;
			end else begin
				byte_pos_q    <= 2'd0;
				assembly_q    <= 24'd0;
				pixels_left_q <= pl_next;
				if (done) begin
					packet_left_q <= 8'd0;
					repeat_q      <= 1'b0;
				end else if (cfg.rle_mode) begin
					packet_left_q <= repeat_q ? 8'd0 : (packet_left_q - 8'd1);
				end
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (take) begin
			vld_s2 <= fire && is_emit;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (fire && is_emit) begin
			result_s2.pixel_value <= pix;
			result_s2.run_count   <= count;
			result_s2.image_done  <= done;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/tga_rle_pixel_decoder_unit.sv */
// ---------------------------------------------------------------------------
// TGA RLE pixel decoder unit
// Decodes a TGA image body, one byte per word, into runs of RGB pixels.
// ---------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   -------   ------------------   ---------------------------------------
//   input     s_tvalid/s_tready    s_tdata: data_byte
//   output    m_tvalid/m_tready    m_tdata: pixel_value, run_count
//                                  m_tlast: image_done
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle while the output does not stall; the byte that
// completes a pixel passes the input register and then the result register.
// Header bytes and middle bytes of a pixel produce no word.
// Reset clears the packet and image counters; the decoder then waits for the
// first byte of a new image, with the registers at their reset values.
// A stalled output word holds, and the input register still takes one more
// byte while the result register is full.
// ---------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Input stream, tdata: data_byte [7:0].
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [7:0]                          s_tdata,
	// Output stream, tdata: pixel_value [31:0], run_count [39:32].
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [39:0]                              m_tdata,
	output logic                                     m_tlast,
	// Configuration write channel.
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [tgarle_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [31:0]                         cfg_data
);

	tgarle_pkg::cfg_t    cfg;
	tgarle_pkg::result_t result_s2;
	logic                take;
	logic                valid_s1;
	logic [7:0]          byte_s1;

	// Configuration registers.
	tgarle_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register.
	tgarle_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// Decoder and result register.
	tgarle_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.take      (take),
		.valid_s2  (m_tvalid),
		.result_s2 (result_s2),
		.out_ready (m_tready)
	);

	// Output word packing.
	assign m_tdata = {result_s2.run_count, result_s2.pixel_value};
	assign m_tlast = result_s2.image_done;

endmodule

`default_nettype wire

/* rtl/core/tgarle_checker.sv */
// ---------------------------------------------------------------------------
// TGA RLE pixel decoder: port checker
// Watches the top level's ports and flags broken stream behaviour.
// ---------------------------------------------------------------------------
`default_nettype none

`include "tga_rle_pixel_decoder_unit_assert.svh"

module tgarle_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [39:0]  m_tdata,
	input wire logic         m_tlast,
	input wire logic         cfg_valid,
	input wire logic         cfg_ready
);

	logic        out_stall;
	logic [40:0] out_word;
	logic        run_ok;

	// Short views of the output side.
	assign out_stall = m_tvalid && !m_tready;
	assign out_word  = {m_tlast, m_tdata};
	assign run_ok    = (m_tdata[39:32] != 8'd0) && (m_tdata[39:32] <= 8'd128);

	// A stalled output word keeps its payload.
	`TGARLE_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(out_word), "stalled word changed")

	// Every run covers between one and one hundred and twenty-eight pixels.
	`TGARLE_ASSERT_NOW(a_run_range, m_tvalid, run_ok, "run count out of range")

	// With no result waiting, the input side must be open.
	`TGARLE_ASSERT_NOW(a_in_open, !m_tvalid, s_tready, "input blocked with empty output")

	// Register writes are never refused.
	`TGARLE_ASSERT_NOW(a_cfg_open, cfg_valid, cfg_ready, "configuration word refused")

endmodule

bind tga_rle_pixel_decoder_unit tgarle_checker u_checker (.*);

`default_nettype wire

/* dv/tga_rle_pixel_decoder_unit_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// TGA RLE pixel decoder unit: testbench
// Streams image body bytes into the decoder, both plain and run-length coded,
// under several register settings. A behavioural decoder in the bench predicts
// every run, and each output word is compared against the oldest prediction.
// ---------------------------------------------------------------------------

module tga_rle_pixel_decoder_unit_tb;

	import tgarle_pkg::*;

	localparam int unsigned SETTLE_CYCLES   = 4;
	localparam int unsigned STALL_LIMIT     = 2000;
	localparam int unsigned HOLD_OFF_CYCLES = 200;
	localparam int unsigned RANDOM_ITEMS    = 1600;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
	localparam logic [31:0] PIXEL_TOTAL_MAX = 32'd4294836225;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [7:0]             s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [39:0]            m_tdata;
	logic                   m_tlast;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [31:0]            cfg_data;

	// Bench copy of the registers and of the decoder state.
	logic        cfg_rle;
	logic [2:0]  cfg_pbytes;
	logic [31:0] cfg_total;
	logic [7:0]  pkt_left;
	logic        pkt_repeat;
	logic [1:0]  pix_pos;
	logic [23:0] pix_acc;
	logic [31:0] img_left;

	result_t                runs_due [$];
	logic [CFG_INDEX_W-1:0] reg_idx_q [$];
	logic [31:0]            reg_val_q [$];

	int unsigned errors = 0;
	int unsigned bytes_sent = 0;
	int unsigned stall_cycles = 0;
	int unsigned rx_hold = 0;
	bit          no_gaps = 1'b0;

	tga_rle_pixel_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Bytes per pixel as the decoder uses them.
	function automatic int unsigned pixel_size();
		if (cfg_pbytes == 3'd0) begin
			return 1;
		end else if (cfg_pbytes > 3'd4) begin
			return 4;
		end
		return cfg_pbytes;
	endfunction

	// Advances the bench decoder by one byte and records the run it yields.
	function automatic void decode_byte(input logic [7:0] b);
		int unsigned nb;
		logic [31:0] pix;
		logic [31:0] cnt;
		result_t     r;
		nb = pixel_size();
		if (img_left == 32'd0) begin
			img_left = (cfg_total == 32'd0) ? 32'd1 : cfg_total;
		end
		// A packet header only loads the packet state.
		if (cfg_rle && pkt_left == 8'd0) begin
			pkt_left = {1'b0, b[6:0]} + 8'd1;
			pkt_repeat = b[7];
			pix_pos = 2'd0;
			pix_acc = 24'd0;
			return;
		end
		if (pix_pos + 1 < nb) begin
			pix_acc = pix_acc | (24'(b) << (8 * pix_pos));
			pix_pos = pix_pos + 2'd1;
			return;
		end
		// Last byte of the pixel: mask to the bytes received, then BGR to RGB.
		pix = {8'h00, pix_acc} | (32'(b) << (8 * pix_pos));
		if (pix_pos < 2'd3) begin
			pix = pix & ((32'd1 << (8 * (pix_pos + 1))) - 32'd1);
		end
		if (nb >= 3) begin
			pix = {pix[31:24], pix[7:0], pix[15:8], pix[23:16]};
		end
		pix_pos = 2'd0;
		pix_acc = 24'd0;
		cnt = 32'd1;
		if (cfg_rle) begin
			if (pkt_repeat) begin
				cnt = {24'd0, pkt_left};
				if (cnt > img_left) begin
					cnt = img_left;
				end
				pkt_left = 8'd0;
			end else begin
				pkt_left = pkt_left - 8'd1;
			end
		end
		if (cnt == 32'd0) begin
			cnt = 32'd1;
		end
		img_left = img_left - cnt;
		r.pixel_value = pix;
		r.run_count = cnt[7:0];
		r.image_done = (img_left == 32'd0);
		if (r.image_done) begin
			pkt_left = 8'd0;
			pkt_repeat = 1'b0;
		end
		runs_due.push_back(r);
	endfunction

	function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
		case (idx)
			CFG_RLE_MODE: begin
				cfg_rle = val[0];
			end
			CFG_PIXEL_BYTES: begin
				cfg_pbytes = val[2:0];
			end
			CFG_PIXEL_TOTAL: begin
				cfg_total = val;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void queue_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
		reg_idx_q.push_back(idx);
		reg_val_q.push_back(val);
	endfunction

	// Writes every queued register back to back; valid drops after the last.
	task automatic flush_regs();
		logic [CFG_INDEX_W-1:0] idx;
		logic [31:0]            val;
		while (reg_idx_q.size() != 0) begin
			idx = reg_idx_q.pop_front();
			val = reg_val_q.pop_front();
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= val;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			apply_reg(idx, val);
		end
		cfg_valid <= 1'b0;
	endtask

	// Offers one byte after a random gap; valid stays high for a following byte.
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		decode_byte(b);
		bytes_sent++;
	endtask

	// Stops the input and waits until every predicted run has been seen, plus
	// a SETTLE_CYCLES wait for a trailing header or middle byte still in the pipe.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (runs_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sends packets with random content; some are cut short to break framing.
	task automatic send_packets(input int unsigned n);
		logic [7:0]  hdr;
		int unsigned len;
		repeat (n) begin
			hdr[7] = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 9) == 0) begin
				hdr[6:0] = 7'($urandom_range(0, 127));
			end else begin
				hdr[6:0] = 7'($urandom_range(0, 7));
			end
			len = (hdr[7] ? 1 : hdr[6:0] + 1) * pixel_size();
			if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(0, len);
			end
			send_byte(hdr);
			repeat (len) send_byte(8'($urandom));
		end
	endtask

	// A random register setting; upper data bits of the narrow registers are
	// filled with noise.
	task automatic pick_config();
		logic [31:0] val;
		if ($urandom_range(0, 2) != 0) begin
			val = $urandom;
			val[0] = ($urandom_range(0, 3) != 0);
			queue_reg(CFG_RLE_MODE, val);
		end
		if ($urandom_range(0, 2) != 0) begin
			val = $urandom;
			if ($urandom_range(0, 4) == 0) begin
				val[2:0] = 3'($urandom_range(0, 7));
			end else begin
				val[2:0] = 3'($urandom_range(1, 4));
			end
			queue_reg(CFG_PIXEL_BYTES, val);
		end
		if ($urandom_range(0, 2) != 0) begin
			case ($urandom_range(0, 9))
				0: val = 32'd0;
				1, 2, 3: val = $urandom_range(17, 200);
				default: val = $urandom_range(1, 16);
			endcase
			queue_reg(CFG_PIXEL_TOTAL, val);
		end
		if ($urandom_range(0, 9) == 0) begin
			queue_reg(CFG_SPARE, $urandom);
		end
		flush_regs();
	endtask

	// Reset values: plain mode, four bytes per pixel, one-pixel image.
	task automatic test_reset_defaults();
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'h03);
		send_byte(8'hFF);
		drain();
	endtask

	// Zero size and total fall back to one; sizes above four act as four, and
	// a long repeat run is clipped to the pixels left.
	task automatic test_size_corners();
		queue_reg(CFG_PIXEL_BYTES, 32'd0);
		queue_reg(CFG_PIXEL_TOTAL, 32'd0);
		flush_regs();
		send_byte(8'h80);
		drain();
		queue_reg(CFG_RLE_MODE, 32'd1);
		queue_reg(CFG_PIXEL_BYTES, 32'd6);
		queue_reg(CFG_PIXEL_TOTAL, 32'd3);
		flush_regs();
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hAA);
		send_byte(8'h55);
		send_byte(8'hFF);
		drain();
	endtask

	// A raw packet longer than the image ends with it; the next bytes open a
	// fresh image with a repeat packet and a one-pixel raw packet.
	task automatic test_raw_past_end();
		queue_reg(CFG_PIXEL_BYTES, 32'd1);
		queue_reg(CFG_PIXEL_TOTAL, 32'd2);
		flush_regs();
		send_byte(8'h7F);
		send_byte(8'h11);
		send_byte(8'h22);
		send_byte(8'h80);
		send_byte(8'h33);
		send_byte(8'h00);
		send_byte(8'h44);
		drain();
	endtask

	// Register changes in the middle of a pixel and of an image.
	task automatic test_live_changes();
		queue_reg(CFG_RLE_MODE, 32'd0);
		queue_reg(CFG_PIXEL_BYTES, 32'd3);
		queue_reg(CFG_PIXEL_TOTAL, 32'd5);
		flush_regs();
		send_byte(8'h10);
		send_byte(8'h20);
		drain();
		// Two bytes already held, so the next byte completes the pixel.
		queue_reg(CFG_PIXEL_BYTES, 32'd2);
		flush_regs();
		send_byte(8'h30);
		drain();
		queue_reg(CFG_RLE_MODE, 32'd1);
		queue_reg(CFG_PIXEL_TOTAL, 32'd9);
		flush_regs();
		send_byte(8'h82);
		send_byte(8'h01);
		send_byte(8'h02);
		drain();
		queue_reg(CFG_RLE_MODE, 32'd0);
		flush_regs();
		send_byte(8'h03);
		send_byte(8'h04);
		send_byte(8'h05);
		send_byte(8'h06);
		drain();
	endtask

	// The receiver holds off for a long stretch while bytes keep coming.
	task automatic test_output_stall();
		queue_reg(CFG_RLE_MODE, 32'd0);
		queue_reg(CFG_PIXEL_BYTES, 32'd1);
		queue_reg(CFG_PIXEL_TOTAL, 32'd50);
		flush_regs();
		rx_hold = HOLD_OFF_CYCLES;
		repeat (40) send_byte(8'($urandom));
		drain();
	endtask

	// Mostly well-formed packet streams, with plain bytes as noise.
	task automatic test_random_streams();
		while (bytes_sent < RANDOM_ITEMS) begin
			drain();
			pick_config();
			no_gaps = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(4, 40)) send_byte(8'($urandom));
			end else begin
				send_packets($urandom_range(2, 12));
			end
		end
		no_gaps = 1'b0;
		drain();
	endtask

	// Finishes the open image, then runs with the largest totals, which never
	// end within the run, so this stays last.
	task automatic test_largest_image();
		int unsigned n;
		queue_reg(CFG_RLE_MODE, 32'd0);
		queue_reg(CFG_PIXEL_BYTES, 32'd1);
		flush_regs();
		n = img_left;
		repeat (n) send_byte(8'($urandom));
		drain();
		queue_reg(CFG_RLE_MODE, 32'hFFFF_FFFF);
		queue_reg(CFG_PIXEL_BYTES, 32'hFFFF_FFFF);
		queue_reg(CFG_PIXEL_TOTAL, PIXEL_TOTAL_MAX);
		flush_regs();
		send_byte(8'hFF);
		repeat (4) send_byte(8'($urandom));
		send_byte(8'h02);
		repeat (12) send_byte(8'($urandom));
		drain();
		queue_reg(CFG_PIXEL_TOTAL, 32'hFFFF_FFFF);
		queue_reg(CFG_SPARE, 32'hFFFF_FFFF);
		flush_regs();
		send_byte(8'h81);
		repeat (4) send_byte(8'($urandom));
		drain();
	endtask

	// Main sequence.
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		cfg_valid = 1'b0;
		cfg_index = CFG_RLE_MODE;
		cfg_data = 32'd0;
		cfg_rle = 1'b0;
		cfg_pbytes = PIXEL_BYTES_RST;
		cfg_total = PIXEL_TOTAL_RST;
		pkt_left = 8'd0;
		pkt_repeat = 1'b0;
		pix_pos = 2'd0;
		pix_acc = 24'd0;
		img_left = 32'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_size_corners();
		test_raw_past_end();
		test_live_changes();
		test_output_stall();
		test_random_streams();
		test_largest_image();
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Output side: a random wait before each word, or one long hold when asked.
	initial begin
		int unsigned wait_n;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold != 0) begin
				wait_n = rx_hold;
				rx_hold = 0;
			end else begin
				wait_n = no_gaps ? 0 : $urandom_range(0, 3);
			end
			if (wait_n != 0) begin
				m_tready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// Each accepted word against the oldest predicted run.
	always @(posedge clk) begin : check_words
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (runs_due.size() == 0) begin
				$display("%0t: unexpected word, pixel %h count %0d last %b", $time,
					m_tdata[31:0], m_tdata[39:32], m_tlast);
				errors++;
			end else begin
				want = runs_due.pop_front();
				if (m_tdata[31:0] !== want.pixel_value) begin
					$display("%0t: pixel_value expected %h, got %h", $time,
						want.pixel_value, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[39:32] !== want.run_count) begin
					$display("%0t: run_count expected %0d, got %0d", $time,
						want.run_count, m_tdata[39:32]);
					errors++;
				end
				if (m_tlast !== want.image_done) begin
					$display("%0t: image_done expected %b, got %b", $time,
						want.image_done, m_tlast);
					errors++;
				end
			end
		end
	end

	// Ends the run when no word moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d runs outstanding", $time,
				STALL_LIMIT, runs_due.size());
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule
